// ----- sv/ghc_pkg.sv -----
// Shared constants, types and helper functions of the hit clustering block.
package ghc_pkg;

   // sizing of the hit store and of the input fields
   localparam int MaxHits     = 64;
   localparam int CoordWidth  = 16;
   localparam int EnergyWidth = 16;

   // effective widths: inputs are 16-bit fields
   localparam int CoordEff    = (CoordWidth < 16) ? CoordWidth : 16;
   localparam int EnergyEff   = (EnergyWidth < 16) ? EnergyWidth : 16;

   localparam int ClusterIdxW = $clog2(MaxHits);
   localparam int TotalW      = $clog2(MaxHits + 1);

   // distance arithmetic
   localparam int SqW  = 2 * CoordEff;
   localparam int SumW = SqW + 2;
   localparam int LimW = 32;
   localparam int CmpW = (SumW > LimW) ? SumW : LimW;

   // result field widths
   localparam int CidW       = 6;
   localparam int CountW     = 7;
   localparam int EnTotalW   = 22;
   localparam int MeanW      = 16;
   localparam int IndexW     = 16;
   localparam int LinkW      = 16;
   localparam int OrGroups   = (MaxHits + 7) / 8;

   localparam logic [LinkW-1:0] LinkReset = 16'd300;

   // input and result kinds
   localparam logic KindHit    = 1'b0;
   localparam logic KindEnd    = 1'b1;
   localparam logic ResAssign  = 1'b0;
   localparam logic ResSummary = 1'b1;

   // new hit as seen by every hit cell
   typedef struct packed {
      logic signed [CoordEff-1:0] x;
      logic signed [CoordEff-1:0] y;
      logic signed [CoordEff-1:0] z;
      logic        [LimW-1:0]     lim;
   } probe_type;

   // update and shift control of the cluster cells
   typedef struct packed {
      logic                 upd;
      logic                 open;
      logic                 shift;
      logic [EnergyEff-1:0] energy;
   } clu_ctl_type;

   // index of the lowest set bit
   function automatic logic [ClusterIdxW-1:0] lowest_set(input logic [MaxHits-1:0] v);
      logic [ClusterIdxW-1:0] r;
      r = '0;
      for (int i = MaxHits - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = ClusterIdxW'(i);
         end
      end
      return r;
   endfunction

endpackage

// ----- sv/ghc_hit_cell.sv -----
// One stored hit: position, cluster id and pipelined distance check.
module ghc_hit_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  ghc_pkg::probe_type            probe,
   input  logic                          wr_en,
   input  logic [ghc_pkg::ClusterIdxW-1:0] wr_cid,
   input  logic                          slot_valid,
   output logic [ghc_pkg::MaxHits-1:0]   match
);

   logic signed [ghc_pkg::CoordEff-1:0]  sx_ff, sy_ff, sz_ff;
   logic [ghc_pkg::ClusterIdxW-1:0]      scid_ff;
   logic [ghc_pkg::CoordEff-1:0]         adx_ff, ady_ff, adz_ff;
   logic [ghc_pkg::CoordEff-1:0]         adx_in, ady_in, adz_in;
   logic [ghc_pkg::SqW-1:0]              sqx_ff, sqy_ff, sqz_ff;
   logic [ghc_pkg::SumW-1:0]             sum_in;
   logic                                 near_ff, near_in;

   function automatic logic [ghc_pkg::CoordEff-1:0] abs_diff(
      input logic signed [ghc_pkg::CoordEff-1:0] a,
      input logic signed [ghc_pkg::CoordEff-1:0] b);
      logic signed [ghc_pkg::CoordEff:0] d;
      logic signed [ghc_pkg::CoordEff:0] n;
      d = (ghc_pkg::CoordEff+1)'(a) - (ghc_pkg::CoordEff+1)'(b);
      n = -d;
      return d[ghc_pkg::CoordEff] ? n[ghc_pkg::CoordEff-1:0] : d[ghc_pkg::CoordEff-1:0];
   endfunction

   // store the hit
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sx_ff   <= probe.x;
         sy_ff   <= probe.y;
         sz_ff   <= probe.z;
         scid_ff <= wr_cid;
      end
   end

   // absolute differences, squares, threshold compare
   always_comb begin
      adx_in  = abs_diff(probe.x, sx_ff);
      ady_in  = abs_diff(probe.y, sy_ff);
      adz_in  = abs_diff(probe.z, sz_ff);
      sum_in  = ghc_pkg::SumW'(sqx_ff) + ghc_pkg::SumW'(sqy_ff) + ghc_pkg::SumW'(sqz_ff);
      near_in = slot_valid &&
                (ghc_pkg::CmpW'(sum_in) <= ghc_pkg::CmpW'(probe.lim));
   end

   always_ff @(posedge clock) begin
      adx_ff <= adx_in;
      ady_ff <= ady_in;
      adz_ff <= adz_in;
      sqx_ff <= ghc_pkg::SqW'(adx_ff) * ghc_pkg::SqW'(adx_ff);
      sqy_ff <= ghc_pkg::SqW'(ady_ff) * ghc_pkg::SqW'(ady_ff);
      sqz_ff <= ghc_pkg::SqW'(adz_ff) * ghc_pkg::SqW'(adz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff <= 1'b0;
      end else begin
         near_ff <= near_in;
      end
   end

   // one-hot cluster vote
   always_comb begin
      match = '0;
      if (near_ff) begin
         match[scid_ff] = 1'b1;
      end
   end

endmodule

// ----- sv/ghc_clu_cell.sv -----
// One cluster record: hit count and energy total, shifted out at end of event.
module ghc_clu_cell (
   input  logic                            clock,
   input  ghc_pkg::clu_ctl_type            ctl,
   input  logic                            sel,
   input  logic [ghc_pkg::CountW-1:0]      next_hits,
   input  logic [ghc_pkg::EnTotalW-1:0]    next_energy,
   output logic [ghc_pkg::CountW-1:0]      hits,
   output logic [ghc_pkg::EnTotalW-1:0]    energy
);

   logic [ghc_pkg::CountW-1:0]   hits_ff, hits_in;
   logic [ghc_pkg::EnTotalW-1:0] energy_ff, energy_in;
   logic [ghc_pkg::EnTotalW:0]   sum;

   // shift from neighbor, or open / accumulate
   always_comb begin
      sum       = (ghc_pkg::EnTotalW+1)'(energy_ff) + (ghc_pkg::EnTotalW+1)'(ctl.energy);
      hits_in   = hits_ff;
      energy_in = energy_ff;
      if (ctl.shift) begin
         hits_in   = next_hits;
         energy_in = next_energy;
      end else if (ctl.upd && sel) begin
         if (ctl.open) begin
            hits_in   = ghc_pkg::CountW'(1);
            energy_in = ghc_pkg::EnTotalW'(ctl.energy);
         end else begin
            hits_in   = hits_ff + ghc_pkg::CountW'(1);
            energy_in = sum[ghc_pkg::EnTotalW] ? '1 : sum[ghc_pkg::EnTotalW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      hits_ff   <= hits_in;
      energy_ff <= energy_in;
   end

   assign hits   = hits_ff;
   assign energy = energy_ff;

endmodule

// ----- sv/ghc_div.sv -----
// Restoring divider: energy total over hit count, one quotient bit a cycle.
module ghc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ghc_pkg::EnTotalW-1:0]  dividend,
   input  logic [ghc_pkg::CountW-1:0]    divisor,
   output logic                          done,
   output logic [ghc_pkg::EnTotalW-1:0]  quotient
);

   localparam int StepW = $clog2(ghc_pkg::EnTotalW);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [StepW-1:0]              step_ff, step_in;
   logic [ghc_pkg::CountW-1:0]    rem_ff, rem_in;
   logic [ghc_pkg::EnTotalW-1:0]  quo_ff, quo_in;
   logic [ghc_pkg::CountW:0]      shifted;
   logic [ghc_pkg::CountW:0]      diff;
   logic                          ge;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, quo_ff[ghc_pkg::EnTotalW-1]};
      diff    = shifted - (ghc_pkg::CountW+1)'(divisor);
      ge      = shifted >= (ghc_pkg::CountW+1)'(divisor);
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[ghc_pkg::CountW-1:0] : shifted[ghc_pkg::CountW-1:0];
         quo_in  = {quo_ff[ghc_pkg::EnTotalW-2:0], ge};
         step_in = step_ff + StepW'(1);
         if (step_ff == StepW'(ghc_pkg::EnTotalW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- sv/greedy_hit_clustering_top.sv -----
// Greedy single-linkage hit clustering: hit cells, cluster cells and control.
// Hit item: 5-stage distance/vote pipeline (hit cells, registered OR), then the
//   decide state, held until the output is free; next item taken once the result loads.
// Full store or empty event: one result, loaded from StOne once the output is free.
// End of event: one summary per cluster, each after the 22-step divider gives its mean.
// Reset (synchronous): store empty, no clusters, link distance 300.
module greedy_hit_clustering_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,   // link_distance
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,     // x_pos, y_pos, z_pos, energy, hit_index
   input  logic        req_tuser,     // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,     // cluster_id, hit_echo, dropped, hit_count,
                                      // energy_total, energy_mean, zero pad
   output logic        rsp_tuser,     // result_kind
   output logic        rsp_tlast      // last
);

   localparam int MH  = ghc_pkg::MaxHits;
   localparam int CIW = ghc_pkg::ClusterIdxW;
   localparam int TW  = ghc_pkg::TotalW;

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StWait   = 3'd1;
   localparam logic [2:0] StDecide = 3'd2;
   localparam logic [2:0] StOne    = 3'd3;
   localparam logic [2:0] StDiv    = 3'd4;
   localparam logic [2:0] StSum    = 3'd5;
   localparam logic [2:0] WaitLast = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  wait_ff, wait_in;
   logic [ghc_pkg::LinkW-1:0] link_ff;
   logic [ghc_pkg::LimW-1:0]  lim_ff;
   logic [TW-1:0] hit_total_ff, hit_total_in;
   logic [TW-1:0] clu_total_ff, clu_total_in;
   logic [TW-1:0] sum_k_ff, sum_k_in;
   logic          div_go_ff, div_go_in;

   // latched input item
   logic                           kind_ff;
   logic signed [ghc_pkg::CoordEff-1:0] hx_ff, hy_ff, hz_ff;
   logic [ghc_pkg::EnergyEff-1:0]  he_ff;
   logic [ghc_pkg::IndexW-1:0]     hidx_ff;

   // output register
   logic                           out_vld_ff;
   logic                           out_kind_ff, out_kind_in;
   logic [ghc_pkg::CidW-1:0]       out_cid_ff, out_cid_in;
   logic [ghc_pkg::IndexW-1:0]     out_echo_ff, out_echo_in;
   logic                           out_drop_ff, out_drop_in;
   logic [ghc_pkg::CountW-1:0]     out_cnt_ff, out_cnt_in;
   logic [ghc_pkg::EnTotalW-1:0]   out_tot_ff, out_tot_in;
   logic [ghc_pkg::MeanW-1:0]      out_mean_ff, out_mean_in;
   logic                           out_last_ff, out_last_in;
   logic                           out_load;
   logic                           out_free;

   ghc_pkg::probe_type   probe;
   ghc_pkg::clu_ctl_type clu_ctl;
   logic [MH-1:0]        match [MH];
   logic [MH-1:0]        or1_ff [ghc_pkg::OrGroups];
   logic [MH-1:0]        or1_in [ghc_pkg::OrGroups];
   logic [MH-1:0]        or2_ff, or2_in;
   logic [CIW-1:0]       new_cid;
   logic                 commit;
   logic [ghc_pkg::CountW-1:0]   c_hits [MH+1];
   logic [ghc_pkg::EnTotalW-1:0] c_energy [MH+1];
   logic                 div_done;
   logic [ghc_pkg::EnTotalW-1:0] quotient;
   logic [ghc_pkg::MeanW-1:0]    mean;
   logic                 accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == StIdle);
   assign out_free   = !out_vld_ff || rsp_tready;

   // configuration and squared link distance
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= ghc_pkg::LinkReset;
      end else if (csr_wr_en) begin
         link_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff <= ghc_pkg::LimW'(link_ff) * ghc_pkg::LimW'(link_ff);
   end

   // capture the item
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_tuser;
         hx_ff   <= req_tdata[ghc_pkg::CoordEff-1:0];
         hy_ff   <= req_tdata[16 +: ghc_pkg::CoordEff];
         hz_ff   <= req_tdata[32 +: ghc_pkg::CoordEff];
         he_ff   <= req_tdata[48 +: ghc_pkg::EnergyEff];
         hidx_ff <= req_tdata[79:64];
      end
   end

   assign probe.x   = hx_ff;
   assign probe.y   = hy_ff;
   assign probe.z   = hz_ff;
   assign probe.lim = lim_ff;

   // row of hit cells
   for (genvar i = 0; i < MH; i++) begin : g_hit
      ghc_hit_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .probe      (probe),
         .wr_en      (commit && (hit_total_ff == TW'(i))),
         .wr_cid     (new_cid),
         .slot_valid (TW'(i) < hit_total_ff),
         .match      (match[i])
      );
   end

   // two-level registered OR of the votes
   always_comb begin
      for (int g = 0; g < ghc_pkg::OrGroups; g++) begin
         or1_in[g] = '0;
      end
      for (int i = 0; i < MH; i++) begin
         or1_in[i / 8] = or1_in[i / 8] | match[i];
      end
      or2_in = '0;
      for (int g = 0; g < ghc_pkg::OrGroups; g++) begin
         or2_in = or2_in | or1_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      or1_ff <= or1_in;
      or2_ff <= or2_in;
   end

   // join the oldest near cluster or open a new one
   always_comb begin
      commit  = (state_ff == StDecide) && out_free;
      new_cid = (or2_ff != '0) ? ghc_pkg::lowest_set(or2_ff) : clu_total_ff[CIW-1:0];
      clu_ctl.upd    = commit;
      clu_ctl.open   = (or2_ff == '0);
      clu_ctl.shift  = (state_ff == StSum) && out_free;
      clu_ctl.energy = he_ff;
   end

   // row of cluster cells, shifting toward cell 0
   assign c_hits[MH]   = '0;
   assign c_energy[MH] = '0;
   for (genvar k = 0; k < MH; k++) begin : g_clu
      ghc_clu_cell u_cell (
         .clock       (clock),
         .ctl         (clu_ctl),
         .sel         (new_cid == CIW'(k)),
         .next_hits   (c_hits[k+1]),
         .next_energy (c_energy[k+1]),
         .hits        (c_hits[k]),
         .energy      (c_energy[k])
      );
   end

   ghc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (c_energy[0]),
      .divisor  (c_hits[0]),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      if (c_hits[0] == '0) begin
         mean = '0;
      end else if (quotient > ghc_pkg::EnTotalW'({ghc_pkg::MeanW{1'b1}})) begin
         mean = '1;
      end else begin
         mean = quotient[ghc_pkg::MeanW-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      hit_total_in = hit_total_ff;
      clu_total_in = clu_total_ff;
      sum_k_in     = sum_k_ff;
      div_go_in    = 1'b0;
      out_load     = 1'b0;
      out_kind_in  = ghc_pkg::ResAssign;
      out_cid_in   = '0;
      out_echo_in  = '0;
      out_drop_in  = 1'b0;
      out_cnt_in   = '0;
      out_tot_in   = '0;
      out_mean_in  = '0;
      out_last_in  = 1'b1;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               if (req_tuser == ghc_pkg::KindEnd) begin
                  if (clu_total_ff == '0) begin
                     state_in = StOne;
                  end else begin
                     state_in  = StDiv;
                     div_go_in = 1'b1;
                     sum_k_in  = '0;
                  end
               end else if (hit_total_ff == TW'(MH)) begin
                  state_in = StOne;
               end else begin
                  state_in = StWait;
                  wait_in  = '0;
               end
            end
         end
         StWait: begin
            wait_in = wait_ff + 3'd1;
            if (wait_ff == WaitLast) begin
               state_in = StDecide;
            end
         end
         StDecide: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_cid_in   = ghc_pkg::CidW'(new_cid);
               out_echo_in  = hidx_ff;
               hit_total_in = hit_total_ff + TW'(1);
               if (or2_ff == '0) begin
                  clu_total_in = clu_total_ff + TW'(1);
               end
               state_in = StIdle;
            end
         end
         StOne: begin
            if (out_free) begin
               out_load = 1'b1;
               if (kind_ff == ghc_pkg::KindEnd) begin
                  out_kind_in = ghc_pkg::ResSummary;
               end else begin
                  out_drop_in = 1'b1;
                  out_echo_in = hidx_ff;
               end
               state_in = StIdle;
            end
         end
         StDiv: begin
            if (div_done) begin
               state_in = StSum;
            end
         end
         StSum: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_kind_in = ghc_pkg::ResSummary;
               out_cid_in  = ghc_pkg::CidW'(sum_k_ff);
               out_cnt_in  = c_hits[0];
               out_tot_in  = c_energy[0];
               out_mean_in = mean;
               out_last_in = (sum_k_ff + TW'(1) == clu_total_ff);
               sum_k_in    = sum_k_ff + TW'(1);
               if (sum_k_ff + TW'(1) == clu_total_ff) begin
                  hit_total_in = '0;
                  clu_total_in = '0;
                  state_in     = StIdle;
               end else begin
                  state_in  = StDiv;
                  div_go_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         wait_ff      <= '0;
         hit_total_ff <= '0;
         clu_total_ff <= '0;
         sum_k_ff     <= '0;
         div_go_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         hit_total_ff <= hit_total_in;
         clu_total_ff <= clu_total_in;
         sum_k_ff     <= sum_k_in;
         div_go_ff    <= div_go_in;
         if (out_load) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_kind_ff <= out_kind_in;
         out_cid_ff  <= out_cid_in;
         out_echo_ff <= out_echo_in;
         out_drop_ff <= out_drop_in;
         out_cnt_ff  <= out_cnt_in;
         out_tot_ff  <= out_tot_in;
         out_mean_ff <= out_mean_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {4'b0, out_mean_ff, out_tot_ff, out_cnt_ff, out_drop_ff,
                        out_echo_ff, out_cid_ff};

   // never more clusters than stored hits, never more hits than cells
   a_totals: assert property (@(posedge clock) disable iff (reset)
      (clu_total_ff <= hit_total_ff) && (hit_total_ff <= TW'(MH)))
      else $error("cluster or hit total out of range");

   // summary walk stays inside the cluster list
   a_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StDiv || state_ff == StSum) |-> (sum_k_ff < clu_total_ff))
      else $error("summary index past cluster total");

   // divider finishes only while a summary waits for it
   a_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == StDiv))
      else $error("divider done outside summary");

   // a commit always stores exactly one hit
   a_commit: assert property (@(posedge clock) disable iff (reset)
      commit |=> (hit_total_ff == $past(hit_total_ff) + TW'(1)))
      else $error("hit not stored on commit");

endmodule
